/* rtl/pair_travel_time_averager_macros.svh */
// Assertion macros for the pair travel-time averager.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef PAIR_TRAVEL_TIME_AVERAGER_MACROS_SVH
`define PAIR_TRAVEL_TIME_AVERAGER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define PTTA_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pair_travel_time_averager: assertion failed");
// Next-cycle implication, checked out of reset.
`define PTTA_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pair_travel_time_averager: assertion failed");
`else
`define PTTA_ASSERT_IMP(lbl, ante, cons)
`define PTTA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/ptta_pkg.sv */
// Shared types and constants for the pair travel-time averager.
// No dependencies; imported by ptta_divider and pair_travel_time_averager.
package ptta_pkg;

    // Default sizing handed to the top-level parameters.
    localparam int CARD_COUNT_DEF    = 256;
    localparam int STATION_COUNT_DEF = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // Fixed field widths.
    localparam int MODE_W    = 2;
    localparam int CARD_W    = 8;
    localparam int STATION_W = 4;
    localparam int TIME_W    = 32;
    localparam int AVG_W     = 56;
    localparam int CNT_W     = 32;
    localparam int TOT_W     = 48;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 136;

    localparam logic [AVG_W-1:0] AVG_MAX = '1;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;
    localparam logic [TOT_W-1:0] TOT_MAX = '1;

    // Transaction kinds carried in the input tuser.
    localparam logic [MODE_W-1:0] MODE_CHECK_IN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CHECK_OUT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY     = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CO_CARD,
        ST_CO_PAIR,
        ST_CO_UPDATE,
        ST_Q_CHECK,
        ST_Q_READ,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/ptta_divider.sv */
// Restoring divider, one quotient bit per cycle, for the average computation.
// Depends on ptta_pkg.
module ptta_divider
    import ptta_pkg::*;
#(
    parameter int DIVIDEND_W = TOT_W + FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [CNT_W-1:0]      divisor,
    output div_stat_t             stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W);

    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      div_reg;
    logic [DIVIDEND_W-1:0] quot_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [CNT_W:0]        shifted;
    logic [CNT_W:0]        diff;
    logic                  fits;

    // One trial subtraction of the divisor from the shifted remainder.
    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, div_reg};
        fits    = (shifted >= {1'b0, div_reg});
    end

    // Control: run for one step per dividend bit, then flag completion.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIVIDEND_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend bits shift out as quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            div_reg  <= divisor;
            quot_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            quot_reg <= {quot_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quot_reg;

endmodule

/* rtl/pair_travel_time_averager.sv */
// Top level of the pair travel-time averager: card and pair stores plus sequencer.
// Depends on ptta_pkg, ptta_divider and pair_travel_time_averager_macros.svh.
//
// Travel statistics per (start, end) station pair. A check-in is written to the
// card store as it is accepted. A check-out steps through card read, pair read
// and read-modify-write of the pair entry, and skips the write when the card has
// no record. A query on a pair with trips runs the bit-serial divider, which
// forms floor((total << FRACTION_BITS) / count) one quotient bit per cycle and
// raises its done flag with the last bit. A query on an empty pair skips the
// divider. A result waits in the output register while the next transaction is
// accepted; a query finishing with the output still full waits for it to drain.
// After reset a clearing pass over max(CARD_COUNT, STATION_COUNT^2) entries
// zeroes both stores, and no input transaction is accepted until it ends.
`include "pair_travel_time_averager_macros.svh"
module pair_travel_time_averager
    import ptta_pkg::*;
#(
    parameter int CARD_COUNT    = CARD_COUNT_DEF,
    parameter int STATION_COUNT = STATION_COUNT_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [7:0] card_id, [11:8] station, [15:12] end_station, [47:16] event_time
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // [1:0] mode
    input  logic [MODE_W-1:0]     s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [55:0] average_time, [87:56] trip_count, [135:88] total_time
    output logic [OUT_DATA_W-1:0] m_tdata,
    // [0] status
    output logic                  m_tuser
);

    localparam int PAIR_COUNT = STATION_COUNT * STATION_COUNT;
    localparam int CW         = $clog2(CARD_COUNT);
    localparam int SW         = $clog2(STATION_COUNT);
    localparam int PW         = $clog2(PAIR_COUNT);
    localparam int CLR_DEPTH  = (CARD_COUNT > PAIR_COUNT) ? CARD_COUNT : PAIR_COUNT;
    localparam int CLRW       = $clog2(CLR_DEPTH);
    localparam int CE_W       = 1 + SW + TIME_W;
    localparam int PE_W       = CNT_W + TOT_W;
    localparam int DW         = TOT_W + FRACTION_BITS;

    // Input field unpacking.
    logic [CARD_W-1:0]    in_card;
    logic [STATION_W-1:0] in_station;
    logic [STATION_W-1:0] in_end;
    logic [TIME_W-1:0]    in_time;
    logic                 in_fire;

    assign in_card    = s_tdata[CARD_W-1:0];
    assign in_station = s_tdata[CARD_W +: STATION_W];
    assign in_end     = s_tdata[CARD_W+STATION_W +: STATION_W];
    assign in_time    = s_tdata[CARD_W+2*STATION_W +: TIME_W];
    assign in_fire    = s_tvalid && s_tready;

    // Sequencer and captured transaction.
    state_t            state_reg, state_next;
    logic [CLRW-1:0]   clr_reg;
    logic [CW-1:0]     card_reg;
    logic              card_ok_reg;
    logic [SW-1:0]     stn_reg;
    logic              stn_ok_reg;
    logic [SW-1:0]     end_reg;
    logic              end_ok_reg;
    logic [TIME_W-1:0] time_reg;
    logic [PW-1:0]     pair_idx_reg;

    // Result staging and output register.
    logic [AVG_W-1:0]  res_avg_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic [TOT_W-1:0]  res_tot_reg;
    logic              res_status_reg;
    logic              out_valid_reg;
    logic [AVG_W-1:0]  out_avg_reg;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [TOT_W-1:0]  out_tot_reg;
    logic              out_status_reg;

    // Stores.
    logic [CE_W-1:0]   card_mem [CARD_COUNT];
    logic [PE_W-1:0]   pair_mem [PAIR_COUNT];
    logic [CE_W-1:0]   card_rd_reg;
    logic [PE_W-1:0]   pair_rd_reg;

    logic              card_we;
    logic [CW-1:0]     card_waddr;
    logic [CE_W-1:0]   card_wdata;
    logic              pair_we;
    logic [PW-1:0]     pair_waddr;
    logic [PE_W-1:0]   pair_wdata;
    logic [PW-1:0]     pair_raddr;

    // Decoded read data and arithmetic.
    logic              rd_valid;
    logic [SW-1:0]     rd_from;
    logic [TIME_W-1:0] rd_time;
    logic [CNT_W-1:0]  rd_cnt;
    logic [TOT_W-1:0]  rd_tot;
    logic [TIME_W-1:0] elapsed;
    logic [TOT_W:0]    sum_wide;
    logic [TOT_W-1:0]  sum_sat;
    logic [CNT_W-1:0]  cnt_inc;
    logic [PW-1:0]     co_pair;
    logic [PW-1:0]     q_pair;
    logic              in_card_ok;
    logic              in_stn_ok;
    logic              clearing_done;
    logic              out_free;

    // Divider interface.
    logic              div_start;
    div_stat_t         div_stat;
    logic [DW-1:0]     div_quot;
    logic [AVG_W-1:0]  avg_sat;

    assign in_card_ok    = (32'(in_card) < CARD_COUNT);
    assign in_stn_ok     = (32'(in_station) < STATION_COUNT);
    assign clearing_done = (clr_reg == CLRW'(CLR_DEPTH - 1));
    assign out_free      = !out_valid_reg || m_tready;

    assign rd_valid = card_rd_reg[CE_W-1];
    assign rd_from  = card_rd_reg[TIME_W +: SW];
    assign rd_time  = card_rd_reg[TIME_W-1:0];
    assign rd_cnt   = pair_rd_reg[PE_W-1:TOT_W];
    assign rd_tot   = pair_rd_reg[TOT_W-1:0];

    // Pair arithmetic for a completed trip, both sums saturating.
    always_comb
    begin
        elapsed  = time_reg - rd_time;
        sum_wide = (TOT_W+1)'(rd_tot) + (TOT_W+1)'(elapsed);
        sum_sat  = sum_wide[TOT_W] ? TOT_MAX : sum_wide[TOT_W-1:0];
        cnt_inc  = (rd_cnt == CNT_MAX) ? CNT_MAX : rd_cnt + 1'b1;
        co_pair  = PW'(32'(rd_from) * STATION_COUNT + 32'(stn_reg));
        q_pair   = PW'(32'(stn_reg) * STATION_COUNT + 32'(end_reg));
        avg_sat  = (div_quot > DW'(AVG_MAX)) ? AVG_MAX : AVG_W'(div_quot);
    end

    // Store write and read address selection.
    always_comb
    begin
        card_we    = 1'b0;
        card_waddr = CW'(clr_reg);
        card_wdata = '0;
        pair_we    = 1'b0;
        pair_waddr = PW'(clr_reg);
        pair_wdata = '0;
        pair_raddr = q_pair;
        if (state_reg == ST_CLEAR)
        begin
            card_we = (int'(clr_reg) < CARD_COUNT);
            pair_we = (int'(clr_reg) < PAIR_COUNT);
        end
        else if (in_fire && s_tuser == MODE_CHECK_IN && in_card_ok && in_stn_ok)
        begin
            card_we    = 1'b1;
            card_waddr = CW'(in_card);
            card_wdata = {1'b1, SW'(in_station), in_time};
        end
        if (state_reg == ST_CO_UPDATE)
        begin
            pair_we    = 1'b1;
            pair_waddr = pair_idx_reg;
            pair_wdata = {cnt_inc, sum_sat};
        end
        if (state_reg == ST_CO_PAIR)
        begin
            pair_raddr = co_pair;
        end
    end

    // Card store: start time, start station and valid flag per card.
    always_ff @(posedge clk)
    begin
        if (card_we)
        begin
            card_mem[card_waddr] <= card_wdata;
        end
        card_rd_reg <= card_mem[card_reg];
    end

    // Pair store: trip count and total time per station pair.
    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_waddr] <= pair_wdata;
        end
        pair_rd_reg <= pair_mem[pair_raddr];
    end

    // Next-state logic and sequencer outputs.
    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clearing_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    priority if (s_tuser == MODE_CHECK_OUT)
                    begin
                        state_next = ST_CO_CARD;
                    end
                    else if (s_tuser == MODE_QUERY)
                    begin
                        state_next = ST_Q_CHECK;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_CO_CARD:
            begin
                state_next = ST_CO_PAIR;
            end
            ST_CO_PAIR:
            begin
                state_next = (rd_valid && card_ok_reg && stn_ok_reg) ? ST_CO_UPDATE : ST_IDLE;
            end
            ST_CO_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_Q_CHECK:
            begin
                state_next = (stn_ok_reg && end_ok_reg) ? ST_Q_READ : ST_EMIT;
            end
            ST_Q_READ:
            begin
                if (rd_cnt == '0)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Captured transaction fields.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            card_reg    <= CW'(in_card);
            card_ok_reg <= in_card_ok;
            stn_reg     <= SW'(in_station);
            stn_ok_reg  <= in_stn_ok;
            end_reg     <= SW'(in_end);
            end_ok_reg  <= (32'(in_end) < STATION_COUNT);
            time_reg    <= in_time;
        end
        if (state_reg == ST_CO_PAIR)
        begin
            pair_idx_reg <= co_pair;
        end
    end

    // Result staging: empty pairs answer with zeros and the empty status.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_Q_CHECK)
        begin
            res_avg_reg    <= '0;
            res_cnt_reg    <= '0;
            res_tot_reg    <= '0;
            res_status_reg <= STATUS_EMPTY;
        end
        else if (state_reg == ST_Q_READ && rd_cnt != '0)
        begin
            res_cnt_reg    <= rd_cnt;
            res_tot_reg    <= rd_tot;
            res_status_reg <= STATUS_OK;
        end
        if (state_reg == ST_DIVIDE && div_stat.done)
        begin
            res_avg_reg <= avg_sat;
        end
    end

    // Output register loaded when the result transaction is free to go.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_avg_reg    <= res_avg_reg;
            out_cnt_reg    <= res_cnt_reg;
            out_tot_reg    <= res_tot_reg;
            out_status_reg <= res_status_reg;
        end
    end

    ptta_divider #(
        .DIVIDEND_W (DW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (DW'(rd_tot) << FRACTION_BITS),
        .divisor  (rd_cnt),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_tot_reg, out_cnt_reg, out_avg_reg};
    assign m_tuser  = out_status_reg;

    // The divider finishes only while the sequencer waits on it.
    `PTTA_ASSERT_IMP(a_div_done_in_divide, div_stat.done, state_reg == ST_DIVIDE)
    // A new result appears only after the emit step.
    `PTTA_ASSERT_IMP(a_result_from_emit, $rose(m_tvalid), $past(state_reg) == ST_EMIT)
    // An empty-pair answer carries all-zero fields.
    `PTTA_ASSERT_IMP(a_empty_is_zero, m_tvalid && m_tuser == STATUS_EMPTY, m_tdata == '0)
    // A successful answer always has at least one trip.
    `PTTA_ASSERT_IMP(a_ok_has_trips, m_tvalid && m_tuser == STATUS_OK, out_cnt_reg != '0)
    // A check-out never leaves a query or result step behind it.
    `PTTA_ASSERT_NXT(a_checkout_path, state_reg == ST_CO_UPDATE, state_reg == ST_IDLE)

endmodule

/* tb/pair_travel_time_averager_tb.sv */
// Self-checking testbench for the pair travel-time averager: stream stimulus and result checks.
// Depends on ptta_pkg and the pair_travel_time_averager RTL; reads nothing else at run time.
module pair_travel_time_averager_tb
    import ptta_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CARDS      = CARD_COUNT_DEF;
    localparam int STATIONS   = STATION_COUNT_DEF;
    localparam int FRAC       = FRACTION_BITS_DEF;
    localparam int PAIRS      = STATIONS * STATIONS;
    localparam int SHOW_LIMIT = 10;

    // The fourth mode code is reserved and ignored by the block.
    localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

    // One query answer as the block reports it.
    typedef struct packed {
        logic [AVG_W-1:0] avg;
        logic [CNT_W-1:0] cnt;
        logic [TOT_W-1:0] tot;
        logic             status;
    } pair_answer_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [MODE_W-1:0]     s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // Predicted contents of the card and pair stores.
    logic [TIME_W-1:0]    trip_start_time [CARDS];
    logic [STATION_W-1:0] trip_start_stn  [CARDS];
    logic                 trip_open       [CARDS];
    logic [CNT_W-1:0]     pair_trips      [PAIRS];
    logic [TOT_W-1:0]     pair_total      [PAIRS];

    pair_answer_t         pending_answers [$];
    logic [CARD_W-1:0]    open_cards      [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatch_count = 0;

    pair_travel_time_averager i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Apply one accepted transaction to the predicted stores and queue any answer.
    function automatic void update_trip_stats(input logic [MODE_W-1:0] mode,
                                              input logic [CARD_W-1:0] card,
                                              input logic [STATION_W-1:0] stn,
                                              input logic [STATION_W-1:0] endst,
                                              input logic [TIME_W-1:0] tm);
        logic [7:0]        pair;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       sum;
        logic [63:0]       quot;
        pair_answer_t      ans;
        case (mode)
            MODE_CHECK_IN:
            begin
                trip_start_time[card] = tm;
                trip_start_stn[card]  = stn;
                trip_open[card]       = 1'b1;
            end
            MODE_CHECK_OUT:
            begin
                // A card without a record is dropped; a valid card stays valid.
                if (trip_open[card])
                begin
                    pair    = {trip_start_stn[card], stn};
                    elapsed = tm - trip_start_time[card];
                    sum     = 64'(pair_total[pair]) + 64'(elapsed);
                    pair_total[pair] = (sum > 64'(TOT_MAX)) ? TOT_MAX : sum[TOT_W-1:0];
                    if (pair_trips[pair] != CNT_MAX)
                        pair_trips[pair] = pair_trips[pair] + 1'b1;
                end
            end
            MODE_QUERY:
            begin
                pair = {stn, endst};
                if (pair_trips[pair] == '0)
                begin
                    ans.avg    = '0;
                    ans.cnt    = '0;
                    ans.tot    = '0;
                    ans.status = STATUS_EMPTY;
                end
                else
                begin
                    quot = (64'(pair_total[pair]) << FRAC) / 64'(pair_trips[pair]);
                    ans.avg    = (quot > 64'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];
                    ans.cnt    = pair_trips[pair];
                    ans.tot    = pair_total[pair];
                    ans.status = STATUS_OK;
                end
                pending_answers.push_back(ans);
            end
            default:
            begin
            end
        endcase
    endfunction

    // Offer one input transaction, with random idle cycles ahead of it.
    task automatic send_item(input logic [MODE_W-1:0] mode,
                             input logic [CARD_W-1:0] card,
                             input logic [STATION_W-1:0] stn,
                             input logic [STATION_W-1:0] endst,
                             input logic [TIME_W-1:0] tm);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {tm, endst, stn, card};
        s_tuser  <= mode;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        update_trip_stats(mode, card, stn, endst, tm);
    endtask

    // Stop offering and wait until every queued answer has come back.
    task automatic wait_for_answers();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_answers.size() != 0)
            @(posedge clk);
    endtask

    // Stations favor a small set so that pairs build up several trips.
    function automatic logic [STATION_W-1:0] pick_station();
        if ($urandom_range(0, 99) < 65)
            return STATION_W'($urandom_range(0, 3));
        return STATION_W'($urandom);
    endfunction

    // Hand-picked corner cases: empty pairs, unrecorded cards, extreme and wrapping times.
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Empty pairs at both ends of the station range.
        send_item(MODE_QUERY, 8'd0, 4'd0, 4'd0, 32'd0);
        send_item(MODE_QUERY, 8'hFF, 4'd15, 4'd15, 32'hFFFF_FFFF);
        // Check-out of a card that never checked in is dropped.
        send_item(MODE_CHECK_OUT, 8'hFF, 4'd15, 4'd0, 32'h1234_5678);
        send_item(MODE_QUERY, 8'd0, 4'd0, 4'd15, 32'd0);
        // Longest possible trip, then a repeated check-out from the same start.
        send_item(MODE_CHECK_IN, 8'd0, 4'd0, 4'd15, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd0, 4'd15, 4'd0, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 8'd0, 4'd0, 4'd15, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd0, 4'd15, 4'd15, 32'd5);
        send_item(MODE_QUERY, 8'd0, 4'd0, 4'd15, 32'd0);
        // Timestamp wraps between check-in and check-out.
        send_item(MODE_CHECK_IN, 8'hFF, 4'd15, 4'd0, 32'hFFFF_FFF0);
        send_item(MODE_CHECK_OUT, 8'hFF, 4'd0, 4'd0, 32'h0000_0010);
        send_item(MODE_QUERY, 8'd0, 4'd15, 4'd0, 32'd0);
        // A second check-in overwrites the first; a zero-length trip counts.
        send_item(MODE_CHECK_IN, 8'hFF, 4'd7, 4'd0, 32'd100);
        send_item(MODE_CHECK_OUT, 8'hFF, 4'd7, 4'd0, 32'd100);
        send_item(MODE_QUERY, 8'd0, 4'd7, 4'd7, 32'd0);
        // Reserved mode leaves everything alone.
        send_item(MODE_RESERVED, 8'hFF, 4'd7, 4'd7, 32'hFFFF_FFFF);
        send_item(MODE_QUERY, 8'd0, 4'd7, 4'd7, 32'd0);
        // Average with a fractional part.
        send_item(MODE_CHECK_IN, 8'd1, 4'd3, 4'd0, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd1, 4'd4, 4'd0, 32'd1);
        send_item(MODE_CHECK_IN, 8'd1, 4'd3, 4'd0, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd1, 4'd4, 4'd0, 32'd2);
        send_item(MODE_QUERY, 8'hAA, 4'd3, 4'd4, 32'hAAAA_AAAA);
        wait_for_answers();
    endtask

    // Pile maximal trips onto one pair so that its total and average grow large.
    task automatic test_long_trips();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(MODE_CHECK_IN, 8'd200, 4'd9, 4'd0, 32'd1);
        repeat (150)
            send_item(MODE_CHECK_OUT, 8'd200, 4'd10, STATION_W'($urandom), 32'd0);
        send_item(MODE_QUERY, 8'd0, 4'd9, 4'd10, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd200, 4'd10, 4'd0, 32'd0);
        send_item(MODE_QUERY, 8'd0, 4'd9, 4'd10, 32'd0);
        send_item(MODE_CHECK_OUT, 8'd200, 4'd10, 4'd0, 32'd4);
        send_item(MODE_QUERY, 8'd0, 4'd9, 4'd10, 32'd0);
        wait_for_answers();
    endtask

    // Mostly well-formed trips and queries, with some noise mixed in.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int n_items);
        int                   done;
        int                   pick;
        int                   r;
        logic [CARD_W-1:0]    card;
        logic [TIME_W-1:0]    elapsed;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        done = 0;
        while (done < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 28)
            begin
                card = ($urandom_range(0, 99) < 75) ? CARD_W'($urandom_range(0, 63))
                                                    : CARD_W'($urandom);
                send_item(MODE_CHECK_IN, card, pick_station(), STATION_W'($urandom),
                          $urandom);
                open_cards.push_back(card);
                if (open_cards.size() > 24)
                    void'(open_cards.pop_front());
                done++;
            end
            else if (pick < 63 && open_cards.size() > 0)
            begin
                card = open_cards[$urandom_range(0, open_cards.size() - 1)];
                r = $urandom_range(0, 99);
                if (r < 70)
                    elapsed = TIME_W'($urandom_range(0, 5000));
                else if (r < 90)
                    elapsed = $urandom;
                else if (r < 95)
                    elapsed = '0;
                else
                    elapsed = '1;
                send_item(MODE_CHECK_OUT, card, pick_station(), STATION_W'($urandom),
                          trip_start_time[card] + elapsed);
                done++;
            end
            else if (pick < 95)
            begin
                send_item(MODE_QUERY, CARD_W'($urandom), pick_station(), pick_station(),
                          $urandom);
                done++;
            end
            else if (pick < 98)
            begin
                // Cards in the upper half are rarely checked in, so most of these drop.
                send_item(MODE_CHECK_OUT, CARD_W'($urandom_range(128, 255)),
                          STATION_W'($urandom), STATION_W'($urandom), $urandom);
                done++;
            end
            else
            begin
                send_item(MODE_RESERVED, CARD_W'($urandom), STATION_W'($urandom),
                          STATION_W'($urandom), $urandom);
            end
        end
        wait_for_answers();
    endtask

    // Hold the result side off for a long stretch while queries keep coming.
    task automatic test_output_backpressure();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left <= 3000;
        for (i = 0; i < 40; i++)
            send_item(MODE_QUERY, CARD_W'($urandom), pick_station(), pick_station(),
                      $urandom);
        wait_for_answers();
    endtask

    // Result-side ready: random stalls, or a counted hold-off when requested.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest predicted answer.
    always @(posedge clk)
    begin : answer_check
        pair_answer_t want;
        pair_answer_t seen;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.avg    = m_tdata[AVG_W-1:0];
            seen.cnt    = m_tdata[AVG_W+CNT_W-1:AVG_W];
            seen.tot    = m_tdata[OUT_DATA_W-1:AVG_W+CNT_W];
            seen.status = m_tuser;
            if (pending_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT)
                    $display("%0t: result with no query pending:", $realtime,
                             " avg=%h cnt=%h tot=%h status=%b",
                             seen.avg, seen.cnt, seen.tot, seen.status);
            end
            else
            begin
                want = pending_answers.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT)
                        $display("%0t: expected avg=%h cnt=%h tot=%h status=%b,",
                                 $realtime, want.avg, want.cnt, want.tot, want.status,
                                 " got avg=%h cnt=%h tot=%h status=%b",
                                 seen.avg, seen.cnt, seen.tot, seen.status);
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        for (int c = 0; c < CARDS; c++)
        begin
            trip_start_time[c] = '0;
            trip_start_stn[c]  = '0;
            trip_open[c]       = 1'b0;
        end
        for (int p = 0; p < PAIRS; p++)
        begin
            pair_trips[p] = '0;
            pair_total[p] = '0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_long_trips();
        test_random_traffic(0, 0, 320);
        test_random_traffic(81, 0, 320);
        test_random_traffic(0, 81, 320);
        test_random_traffic(16, 16, 320);
        test_output_backpressure();

        // Let any trailing check-out finish before the verdict.
        wait_for_answers();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && pending_answers.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
